>>> src/pest_pkg.sv
// ============================================================================
// pest_pkg
// Shared types and constants of the periodic event slot table.
// ============================================================================
package pest_pkg;

    localparam int SLOT_COUNT  = 16;
    localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int MAX_RESULTS = 16;
    localparam int FIRE_W      = $clog2(MAX_RESULTS + 1);

    localparam int PERIOD_W = 16;
    localparam int SIDX_W   = 4;
    localparam int TICK_W   = 32;
    localparam int COORD_W  = 16;
    localparam int FLAG_W   = 8;
    localparam int RSLOT_W  = 4;

    localparam int DIV_STEP_W = $clog2(TICK_W);

    localparam int IN_FIELDS_W  = PERIOD_W + SIDX_W + TICK_W + 2 * COORD_W + FLAG_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 1 + RSLOT_W + 2 * COORD_W + FLAG_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        MODE_ADD  = 2'd0,
        MODE_DEL  = 2'd1,
        MODE_TICK = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        KIND_ADD  = 2'd0,
        KIND_DEL  = 2'd1,
        KIND_FIRE = 2'd2,
        KIND_NONE = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_DEL,
        S_TICK_RD,
        S_TICK_TEST,
        S_DIV,
        S_TICK_ADV,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic                set_en;
        logic                clr_en;
        logic [SLOT_W-1:0]   addr;
        logic [PERIOD_W-1:0] period;
    } t_tbl_cmd;

    typedef struct packed {
        logic                start;
        logic [TICK_W-1:0]   dividend;
        logic [PERIOD_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
        logic rem_zero;
    } t_div_sts;

endpackage

>>> src/periodic_event_slot_table.sv
// Tick: slots are read and tested in order; an active slot with nonzero period also runs the
// bit-serial 32-bit modulo unit, and each fired result is pushed out.
// One request at a time; the next is taken while the last result waits on m_axis.
// Reset (synchronous, active low) frees every slot at once; no clearing pass.
// ============================================================================
// periodic_event_slot_table
// Slot table with add, delete and tick dispatch over a shared modulo unit.
// ============================================================================
module periodic_event_slot_table import pest_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // period, slot_index, tick_count, x_coord, y_coord, activity_flag, zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // mode
    input  logic [1:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // success, result_slot, out_x, out_y, out_flag, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // kind
    output logic [1:0]             m_axis_tuser,
    output logic                   m_axis_tlast
);

    localparam int P_LO = 0;
    localparam int S_LO = P_LO + PERIOD_W;
    localparam int T_LO = S_LO + SIDX_W;
    localparam int X_LO = T_LO + TICK_W;
    localparam int Y_LO = X_LO + COORD_W;
    localparam int F_LO = Y_LO + COORD_W;

    t_state r_state, n_state;

    logic [PERIOD_W-1:0] r_in_period;
    logic [SIDX_W-1:0]   r_in_sidx;
    logic [TICK_W-1:0]   r_in_tick;
    logic [COORD_W-1:0]  r_in_x;
    logic [COORD_W-1:0]  r_in_y;
    logic [FLAG_W-1:0]   r_in_flag;

    logic [SLOT_W-1:0]   r_ctr, n_ctr;
    logic [FIRE_W-1:0]   r_fire_cnt, n_fire_cnt;
    logic                r_held_vld, n_held_vld;
    logic [RSLOT_W-1:0]  r_held_slot, n_held_slot;

    t_kind               r_res_kind, n_res_kind;
    logic                r_res_ok, n_res_ok;
    logic [RSLOT_W-1:0]  r_res_slot, n_res_slot;
    logic                r_res_fire, n_res_fire;
    logic                r_res_last, n_res_last;
    logic                r_ret_idle, n_ret_idle;

    logic                r_m_valid;
    t_kind               r_o_kind;
    logic                r_o_ok;
    logic [RSLOT_W-1:0]  r_o_slot;
    logic [COORD_W-1:0]  r_o_x;
    logic [COORD_W-1:0]  r_o_y;
    logic [FLAG_W-1:0]   r_o_flag;
    logic                r_o_last;

    t_tbl_cmd              w_tbl_cmd;
    t_div_req              w_div_req;
    t_div_sts              w_div_sts;
    logic [PERIOD_W-1:0]   w_rd_period;
    logic [SLOT_COUNT-1:0] w_active;

    logic                w_accept;
    logic                w_out_free;
    logic                w_push;
    logic [SLOT_W-1:0]   w_del_idx;
    logic                w_del_ok;
    logic                w_last_slot;

    pest_slot_table u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_tbl_cmd),
        .i_rd_addr   (r_ctr),
        .o_rd_period (w_rd_period),
        .o_active    (w_active)
    );

    pest_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_sts   (w_div_sts)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_m_valid || m_axis_tready;
    assign w_push        = (r_state == S_PUSH) && w_out_free;
    assign w_last_slot   = (r_ctr == SLOT_W'(SLOT_COUNT - 1));

    // out-of-range slot numbers must not alias onto a real slot
    assign w_del_idx = SLOT_W'(r_in_sidx);
    assign w_del_ok  = ({{(32-SIDX_W){1'b0}}, r_in_sidx} < 32'(SLOT_COUNT))
                       && w_active[w_del_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_ctr       = r_ctr;
        n_fire_cnt  = r_fire_cnt;
        n_held_vld  = r_held_vld;
        n_held_slot = r_held_slot;
        n_res_kind  = r_res_kind;
        n_res_ok    = r_res_ok;
        n_res_slot  = r_res_slot;
        n_res_fire  = r_res_fire;
        n_res_last  = r_res_last;
        n_ret_idle  = r_ret_idle;

        w_tbl_cmd        = '0;
        w_tbl_cmd.addr   = r_ctr;
        w_tbl_cmd.period = r_in_period;

        w_div_req.start    = 1'b0;
        w_div_req.dividend = r_in_tick;
        w_div_req.divisor  = w_rd_period;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_ctr = '0;
                    unique case (s_axis_tuser)
                        MODE_ADD: n_state = S_ADD;
                        MODE_DEL: n_state = S_DEL;
                        MODE_TICK: begin
                            n_fire_cnt = '0;
                            n_held_vld = 1'b0;
                            n_state    = S_TICK_RD;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD: begin
                n_res_kind = KIND_ADD;
                n_res_fire = 1'b0;
                n_res_last = 1'b1;
                n_ret_idle = 1'b1;
                if (!w_active[r_ctr]) begin
                    w_tbl_cmd.set_en = 1'b1;
                    n_res_ok   = 1'b1;
                    n_res_slot = RSLOT_W'(r_ctr);
                    n_state    = S_PUSH;
                end else if (w_last_slot) begin
                    n_res_ok   = 1'b0;
                    n_res_slot = '0;
                    n_state    = S_PUSH;
                end else begin
                    n_ctr = r_ctr + 1'b1;
                end
            end
            S_DEL: begin
                w_tbl_cmd.clr_en = w_del_ok;
                w_tbl_cmd.addr   = w_del_idx;
                n_res_kind = KIND_DEL;
                n_res_ok   = w_del_ok;
                n_res_slot = r_in_sidx;
                n_res_fire = 1'b0;
                n_res_last = 1'b1;
                n_ret_idle = 1'b1;
                n_state    = S_PUSH;
            end
            S_TICK_RD: begin
                n_state = S_TICK_TEST;
            end
            S_TICK_TEST: begin
                if (w_active[r_ctr] && (w_rd_period != '0)) begin
                    w_div_req.start = 1'b1;
                    n_state = S_DIV;
                end else begin
                    n_state = S_TICK_ADV;
                end
            end
            S_DIV: begin
                if (w_div_sts.done) begin
                    n_state = S_TICK_ADV;
                    if (w_div_sts.rem_zero) begin
                        // the earlier fire is not the last one; send it now
                        n_fire_cnt  = r_fire_cnt + 1'b1;
                        n_held_vld  = 1'b1;
                        n_held_slot = RSLOT_W'(r_ctr);
                        if (r_held_vld) begin
                            n_res_kind = KIND_FIRE;
                            n_res_ok   = 1'b0;
                            n_res_slot = r_held_slot;
                            n_res_fire = 1'b1;
                            n_res_last = 1'b0;
                            n_ret_idle = 1'b0;
                            n_state    = S_PUSH;
                        end
                    end
                end
            end
            S_TICK_ADV: begin
                if ((r_fire_cnt == FIRE_W'(MAX_RESULTS)) || w_last_slot) begin
                    n_res_ok   = 1'b0;
                    n_res_last = 1'b1;
                    n_ret_idle = 1'b1;
                    n_state    = S_PUSH;
                    if (r_held_vld) begin
                        n_res_kind = KIND_FIRE;
                        n_res_slot = r_held_slot;
                        n_res_fire = 1'b1;
                        n_held_vld = 1'b0;
                    end else begin
                        n_res_kind = KIND_NONE;
                        n_res_slot = '0;
                        n_res_fire = 1'b0;
                    end
                end else begin
                    n_ctr   = r_ctr + 1'b1;
                    n_state = S_TICK_RD;
                end
            end
            S_PUSH: begin
                if (w_out_free) begin
                    n_state = r_ret_idle ? S_IDLE : S_TICK_ADV;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr      <= '0;
            r_fire_cnt <= '0;
            r_held_vld <= 1'b0;
            r_ret_idle <= 1'b1;
        end else begin
            r_ctr      <= n_ctr;
            r_fire_cnt <= n_fire_cnt;
            r_held_vld <= n_held_vld;
            r_ret_idle <= n_ret_idle;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held_slot <= n_held_slot;
        r_res_kind  <= n_res_kind;
        r_res_ok    <= n_res_ok;
        r_res_slot  <= n_res_slot;
        r_res_fire  <= n_res_fire;
        r_res_last  <= n_res_last;
        if (w_accept) begin
            r_in_period <= s_axis_tdata[S_LO-1:P_LO];
            r_in_sidx   <= s_axis_tdata[T_LO-1:S_LO];
            r_in_tick   <= s_axis_tdata[X_LO-1:T_LO];
            r_in_x      <= s_axis_tdata[Y_LO-1:X_LO];
            r_in_y      <= s_axis_tdata[F_LO-1:Y_LO];
            r_in_flag   <= s_axis_tdata[F_LO+FLAG_W-1:F_LO];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_push) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_o_kind <= r_res_kind;
            r_o_ok   <= r_res_ok;
            r_o_slot <= r_res_slot;
            r_o_x    <= r_res_fire ? r_in_x    : '0;
            r_o_y    <= r_res_fire ? r_in_y    : '0;
            r_o_flag <= r_res_fire ? r_in_flag : '0;
            r_o_last <= r_res_last;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = OUT_TDATA_W'({r_o_flag, r_o_y, r_o_x, r_o_slot, r_o_ok});
    assign m_axis_tuser  = r_o_kind;
    assign m_axis_tlast  = r_o_last;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (s_axis_tuser == MODE_ADD || s_axis_tuser == MODE_DEL
                     || s_axis_tuser == MODE_TICK) |=> !s_axis_tready)
        else $error("ready held after a request");
    a_fire_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fire_cnt <= FIRE_W'(MAX_RESULTS))
        else $error("fire count past limit");
    a_no_held_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_held_vld)
        else $error("fired slot left undelivered");
    a_div_in_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_sts.done |-> (r_state == S_DIV))
        else $error("modulo result outside a tick");
`endif

endmodule

>>> src/pest_mod_unit.sv
// ============================================================================
// pest_mod_unit
// Restoring remainder unit: 32-bit dividend by 16-bit divisor, one bit a cycle.
// ============================================================================
module pest_mod_unit import pest_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_sts o_sts
);

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_STEP_W-1:0] r_step;
    logic [TICK_W-1:0]     r_dvd;
    logic [PERIOD_W-1:0]   r_div;
    logic [PERIOD_W-1:0]   r_rem;

    logic [PERIOD_W:0]     w_trial;
    logic [PERIOD_W:0]     w_diff;
    logic [PERIOD_W-1:0]   n_rem;

    // remainder stays below the divisor, so the trial fits below twice it
    always_comb begin
        w_trial = {r_rem, r_dvd[TICK_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        n_rem   = (w_trial >= {1'b0, r_div}) ? w_diff[PERIOD_W-1:0]
                                             : w_trial[PERIOD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_step == DIV_STEP_W'(TICK_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[TICK_W-2:0], 1'b0};
        end
    end

    assign o_sts.busy     = r_busy;
    assign o_sts.done     = r_done;
    assign o_sts.rem_zero = (r_rem == '0);

`ifndef SYNTHESIS
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_div))
        else $error("remainder not below divisor");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy && !r_done)
        else $error("divider restarted while in use");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(r_busy))
        else $error("done without a run");
`endif

endmodule

>>> src/pest_slot_table.sv
// ============================================================================
// pest_slot_table
// Slot storage: active bits in flops, periods in a small memory.
// ============================================================================
module pest_slot_table import pest_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_tbl_cmd              i_cmd,
    input  logic [SLOT_W-1:0]     i_rd_addr,
    output logic [PERIOD_W-1:0]   o_rd_period,
    output logic [SLOT_COUNT-1:0] o_active
);

    logic [PERIOD_W-1:0]   r_period_mem [SLOT_COUNT];
    logic [PERIOD_W-1:0]   r_rd_period;
    logic [SLOT_COUNT-1:0] r_active;

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_en) begin
            r_period_mem[i_cmd.addr] <= i_cmd.period;
        end
        r_rd_period <= r_period_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_cmd.set_en) begin
            r_active[i_cmd.addr] <= 1'b1;
        end else if (i_cmd.clr_en) begin
            r_active[i_cmd.addr] <= 1'b0;
        end
    end

    assign o_rd_period = r_rd_period;
    assign o_active    = r_active;

`ifndef SYNTHESIS
    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.set_en && i_cmd.clr_en))
        else $error("set and clear together");
    a_set_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.set_en |-> !r_active[i_cmd.addr])
        else $error("add claimed an active slot");
    a_clr_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr_en |=> !r_active[$past(i_cmd.addr)])
        else $error("slot still active after delete");
`endif

endmodule
